### rtl/longest_prefix_route_lookup_core_defines.svh
// Assertion macros shared by the route lookup RTL.
// Included by every file that carries concurrent assertions.
`ifndef LONGEST_PREFIX_ROUTE_LOOKUP_CORE_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define LPRL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LPRL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lprl_pkg.sv
// Shared types, status codes and the prefix mask function for the route lookup.
// No dependencies; imported by the cell and the top level.
package lprl_pkg;

    typedef enum logic [2:0] {
        STAT_FORWARDED   = 3'd0,
        STAT_TTL_EXPIRED = 3'd1,
        STAT_NO_ROUTE    = 3'd2,
        STAT_ADDED       = 3'd3,
        STAT_FULL        = 3'd4
    } lprl_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } lprl_state_t;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;
    localparam int PORT_W = 4;
    localparam int TTL_W  = 8;
    localparam int HOP_W  = ADDR_W + 1;   // bit ADDR_W marks an explicit hop

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  len;
        logic [HOP_W-1:0]  hop;
        logic [PORT_W-1:0] port;
    } lprl_route_t;

    // Search item handed from cell to cell, carrying the best match so far.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] dst;
        logic              found;
        logic [LEN_W-1:0]  best_len;
        logic [PORT_W-1:0] port;
        logic [HOP_W-1:0]  hop;
    } lprl_token_t;

    // High-order mask of len bits, len in 0..32.
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] ones;
        ones = '1;
        return ~(ones >> len);
    endfunction

endpackage

### rtl/lprl_cell.sv
// One table slot of the lookup chain: holds a route and refines the passing search item.
// Depends on lprl_pkg.
module lprl_cell import lprl_pkg::*; #(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  lprl_route_t      wr_route,
    input  logic [CNT_W-1:0] count,
    input  lprl_token_t      tok_in,
    output lprl_token_t      tok_out
);

    lprl_route_t route_reg;
    lprl_token_t tok_reg;
    lprl_token_t tok_next;
    logic        in_use;
    logic        hit;

    assign in_use = CNT_W'(IDX) < count;

    always_comb begin
        tok_next = tok_in;
        // Later slot wins on equal length, so compare with >=.
        hit = in_use
            && (((tok_in.dst ^ route_reg.prefix) & len_mask(route_reg.len)) == '0)
            && (route_reg.len >= tok_in.best_len);
        if (hit) begin
            tok_next.found    = 1'b1;
            tok_next.best_len = route_reg.len;
            tok_next.port     = route_reg.port;
            tok_next.hop      = route_reg.hop;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            route_reg <= wr_route;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### rtl/longest_prefix_route_lookup_core.sv
// Channel  | Dir | tuser       | tdata bits used
// s_       | in  | mode (1)    | prefix, len, hop_given, via, out_port, dst, ttl (115 of 120)
// m_       | out | none        | status, port, hop_addr, ttl_out (47 of 48)
//
// A route add or an expired datagram passes from accept through the result state into the output register.
// A lookup walks its item through all MAX_ROUTES cells, one per cycle, and then
// through the result state; the length of the cell chain sets how long it takes.
// Reset clears the state, the route count, the chain valid bits and the output valid bit.
// A stalled m_ side holds one finished result while the next item is accepted.
`include "longest_prefix_route_lookup_core_defines.svh"

module longest_prefix_route_lookup_core import lprl_pkg::*; #(
    parameter int MAX_ROUTES = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [0] mode
    input  logic [0:0]   s_tuser,
    // [31:0] prefix, [37:32] prefix_len, [38] hop_given,
    // [70:39] via_addr, [74:71] out_port, [106:75] dst_addr, [114:107] ttl
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] status, [6:3] port, [38:7] hop_addr, [46:39] ttl_out
    output logic [47:0]  m_tdata
);

    localparam int CNT_W = $clog2(MAX_ROUTES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ROUTES);

    logic              in_mode;
    logic [ADDR_W-1:0] in_prefix;
    logic [LEN_W-1:0]  in_len;
    logic              in_hop_given;
    logic [ADDR_W-1:0] in_next_hop;
    logic [PORT_W-1:0] in_port;
    logic [ADDR_W-1:0] in_dst;
    logic [TTL_W-1:0]  in_ttl;

    assign in_mode      = s_tuser[0];
    assign in_prefix    = s_tdata[31:0];
    assign in_len       = s_tdata[37:32];
    assign in_hop_given = s_tdata[38];
    assign in_next_hop  = s_tdata[70:39];
    assign in_port      = s_tdata[74:71];
    assign in_dst       = s_tdata[106:75];
    assign in_ttl       = s_tdata[114:107];

    lprl_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    lprl_status_t      res_status_reg, res_status_next;
    logic [PORT_W-1:0] res_port_reg, res_port_next;
    logic [ADDR_W-1:0] res_hop_reg, res_hop_next;
    logic [TTL_W-1:0]  res_ttl_reg, res_ttl_next;
    logic [TTL_W-1:0]  ttl_reg, ttl_next;
    logic              m_valid_reg, m_valid_next;
    logic [47:0]       m_data_reg, m_data_next;

    logic              accept;
    logic              add_fire;
    logic              launch;
    lprl_route_t       wr_route;
    lprl_token_t       tok [MAX_ROUTES+1];
    lprl_token_t       tail;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign add_fire = accept && !in_mode && (count_reg != CNT_FULL);
    assign launch   = accept && in_mode && (in_ttl > TTL_W'(1));

    always_comb begin
        wr_route.prefix = in_prefix;
        wr_route.len    = (in_len > MAX_LEN) ? MAX_LEN : in_len;
        wr_route.hop    = in_hop_given ? {1'b1, in_next_hop} : '0;
        wr_route.port   = in_port;
    end

    always_comb begin
        tok[0].valid    = launch;
        tok[0].dst      = in_dst;
        tok[0].found    = 1'b0;
        tok[0].best_len = '0;
        tok[0].port     = '0;
        tok[0].hop      = '0;
    end

    for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
        lprl_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (add_fire && (count_reg == CNT_W'(i))),
            .wr_route (wr_route),
            .count    (count_reg),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    assign tail = tok[MAX_ROUTES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_port_reg   <= res_port_next;
        res_hop_reg    <= res_hop_next;
        res_ttl_reg    <= res_ttl_next;
        ttl_reg        <= ttl_next;
        m_data_reg     <= m_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_port_next   = res_port_reg;
        res_hop_next    = res_hop_reg;
        res_ttl_next    = res_ttl_reg;
        ttl_next        = ttl_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_port_next = '0;
                    res_hop_next  = '0;
                    res_ttl_next  = '0;
                    ttl_next      = in_ttl - TTL_W'(1);
                    if (!in_mode) begin
                        if (count_reg == CNT_FULL) begin
                            res_status_next = STAT_FULL;
                        end else begin
                            res_status_next = STAT_ADDED;
                            count_next      = count_reg + CNT_W'(1);
                        end
                        state_next = ST_RESULT;
                    end else if (!launch) begin
                        res_status_next = STAT_TTL_EXPIRED;
                        state_next      = ST_RESULT;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (tail.valid) begin
                    if (tail.found) begin
                        res_status_next = STAT_FORWARDED;
                        res_port_next   = tail.port;
                        res_hop_next    = tail.hop[ADDR_W] ? tail.hop[ADDR_W-1:0] : tail.dst;
                        res_ttl_next    = ttl_reg;
                    end else begin
                        res_status_next = STAT_NO_ROUTE;
                    end
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                // Load the output register once it is free or being drained.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, res_ttl_reg, res_hop_reg, res_port_reg,
                                    res_status_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `LPRL_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_FULL,
        "route count beyond table size")
    `LPRL_ASSERT_NOW(a_tail_in_scan, aclk, aresetn, tail.valid, state_reg == ST_SCAN,
        "search item left the chain outside a scan")
    `LPRL_ASSERT_NEXT(a_add_counts, aclk, aresetn, add_fire,
        count_reg == $past(count_reg) + CNT_W'(1), "route add did not advance count")
    `LPRL_ASSERT_NOW(a_full_status, aclk, aresetn,
        m_valid_reg && (m_data_reg[2:0] == STAT_FULL), count_reg == CNT_FULL,
        "table full reported with free slots")

endmodule
